// ----- rtl/scheduled_gamma_led_dimmer_macros.svh -----
// Assertion macros for the scheduled gamma LED dimmer checker.
// The macros expect i_clk and i_rst_n in the scope where they are used.
`ifndef SCHEDULED_GAMMA_LED_DIMMER_MACROS_SVH
`define SCHEDULED_GAMMA_LED_DIMMER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SGLD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SGLD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sgld_pkg.sv -----
// Shared constants, types, state codes and ROM builders for the LED dimmer.
// Used by every .sv file under rtl; depends on nothing else.
`default_nettype none

package sgld_pkg;

    localparam int unsigned PWM_MAX            = 1023;
    localparam int unsigned BREATH_PERIOD_MS   = 6000;
    localparam int unsigned BREATH_INTERVAL_MS = 5;
    localparam int unsigned TABLE_DEPTH        = 1024;

    localparam int unsigned FULL_SIXTEENTHS  = 1600;
    localparam int unsigned HALF_STEP        = FULL_SIXTEENTHS / 2;
    localparam int unsigned STATUS_THRESHOLD = 8;
    localparam int unsigned PCT_MAX          = 100;
    localparam int unsigned Q16_ONE          = 65536;
    localparam int unsigned Q16_HALF         = 32768;

    localparam int unsigned GIDX_W = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned WIDX_W = $clog2(TABLE_DEPTH);
    localparam int unsigned DIV_MAX = (BREATH_PERIOD_MS > FULL_SIXTEENTHS) ?
                                      BREATH_PERIOD_MS : FULL_SIXTEENTHS;
    localparam int unsigned DIV_W = $clog2(DIV_MAX + 1);

    localparam logic [31:0] RECIP_FULL   = 32'((64'd1 << 32) / FULL_SIXTEENTHS);
    localparam logic [31:0] RECIP_PERIOD = 32'((64'd1 << 32) / BREATH_PERIOD_MS);

    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint unsigned TAYLOR_DIV [6] = '{6, 20, 42, 72, 110, 156};

    localparam int unsigned APB_AW = 5;

    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_SCHED_EN   = 3'd0;
    localparam t_reg_idx REG_ON_MIN     = 3'd1;
    localparam t_reg_idx REG_OFF_MIN    = 3'd2;
    localparam t_reg_idx REG_USER_PCT   = 3'd3;
    localparam t_reg_idx REG_BREATH_MIN = 3'd4;
    localparam t_reg_idx REG_BREATH_MAX = 3'd5;

    localparam logic CMD_SCHEDULE = 1'b0;
    localparam logic CMD_BREATH   = 1'b1;

    typedef logic t_st_addr;
    localparam t_st_addr ST_APPLIED = 1'b0;
    localparam t_st_addr ST_BREATH  = 1'b1;

    typedef logic [16:0] t_q16;
    typedef t_q16 t_gamma_tab [TABLE_DEPTH + 1];
    typedef t_q16 t_wave_tab [TABLE_DEPTH];

    typedef struct packed {
        logic       sched_en;
        logic [10:0] on_min;
        logic [10:0] off_min;
        logic [6:0]  user_pct;
        logic [6:0]  breath_min;
        logic [6:0]  breath_max;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        sched_en:   1'b0,
        on_min:     11'd0,
        off_min:    11'd0,
        user_pct:   7'd100,
        breath_min: 7'd5,
        breath_max: 7'd60
    };

    typedef struct packed {
        logic        command;
        logic [10:0] minute_of_day;
        logic        force_req;
        logic [31:0] time_ms;
    } t_item;

    typedef struct packed {
        logic        drive_updated;
        logic [9:0]  pwm_level;
        logic        status_led;
        logic        window_active;
        logic [10:0] brightness_sixteenths;
    } t_result;

    typedef struct packed {
        logic        rd_en;
        t_st_addr    rd_addr;
        logic        wr_en;
        t_st_addr    wr_addr;
        logic [31:0] wr_data;
    } t_st_req;

    typedef struct packed {
        logic              gamma_en;
        logic [GIDX_W-1:0] gamma_addr;
        logic              wave_en;
        logic [WIDX_W-1:0] wave_addr;
    } t_rom_req;

    typedef struct packed {
        t_q16 gamma;
        t_q16 wave;
    } t_rom_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_BIDX,
        S_DIVM,
        S_DIVC,
        S_MODX,
        S_WRD,
        S_WAVE,
        S_GRD,
        S_PWM,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_MOD,
        PH_IDX,
        PH_GAMMA
    } t_phase;

    // Gamma 2.2 curve in Q16: v^2 times the fifth root of v, v in Q16.
    function automatic t_gamma_tab build_gamma_tab();
        t_gamma_tab        tab;
        longint unsigned   idx;
        longint unsigned   v;
        longint unsigned   lim;
        longint unsigned   lo;
        longint unsigned   hi;
        longint unsigned   mid;
        longint unsigned   p;
        for (int i = 0; i <= int'(TABLE_DEPTH); i++) begin
            idx = longint'(i);
            if (i == 0) begin
                tab[i] = '0;
            end else begin
                v   = (idx * 64'd65536 + TABLE_DEPTH / 2) / TABLE_DEPTH;
                lim = v << 44;
                lo  = 0;
                hi  = 4096;
                while (lo < hi) begin
                    mid = (lo + hi + 1) >> 1;
                    p   = mid * mid * mid * mid * mid;
                    if (p <= lim) begin
                        lo = mid;
                    end else begin
                        hi = mid - 1;
                    end
                end
                tab[i] = t_q16'((v * v * lo + (64'd1 << 27)) >> 28);
            end
        end
        return tab;
    endfunction

    // Breathing wave 0.5 - 0.5 cos in Q16, formed as sin^2 of half the angle.
    function automatic t_wave_tab build_wave_tab();
        t_wave_tab       tab;
        longint unsigned jj;
        longint unsigned k;
        longint unsigned t;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned s;
        longint unsigned w;
        for (int j = 0; j < int'(TABLE_DEPTH); j++) begin
            jj   = longint'(j);
            k    = (TABLE_DEPTH - jj < jj) ? TABLE_DEPTH - jj : jj;
            t    = k * PI_Q30 / TABLE_DEPTH;
            x2   = (t * t) >> 30;
            term = t;
            s    = t;
            for (int n = 0; n < 6; n++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[n];
                if ((n % 2) == 0) begin
                    s = (s > term) ? s - term : 0;
                end else begin
                    s = s + term;
                end
            end
            w      = (s * s + (64'd1 << 43)) >> 44;
            tab[j] = t_q16'((w > Q16_ONE) ? Q16_ONE : w);
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sgld_state_mem.sv -----
// Two-entry state memory: applied percent and last breathing tick time.
// Registered read, one write port, valid bits give the zero reset value.
// Depends on sgld_pkg.
`default_nettype none

module sgld_state_mem (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire sgld_pkg::t_st_req i_req,
    output logic [31:0]           o_rd_data
);

    logic [31:0] r_mem [2];
    logic [1:0]  r_vld;
    logic [31:0] r_rd_data;
    logic        r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[i_req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
            r_rd_vld  <= r_vld[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

// ----- rtl/sgld_rom.sv -----
// Gamma and breathing wave ROMs with registered reads.
// Contents are built at elaboration by the functions in sgld_pkg.
`default_nettype none

module sgld_rom (
    input  wire logic               i_clk,
    input  wire sgld_pkg::t_rom_req i_req,
    output sgld_pkg::t_rom_rsp      o_rsp
);

    localparam sgld_pkg::t_gamma_tab GAMMA_ROM = sgld_pkg::build_gamma_tab();
    localparam sgld_pkg::t_wave_tab  WAVE_ROM  = sgld_pkg::build_wave_tab();

    sgld_pkg::t_q16 r_gamma;
    sgld_pkg::t_q16 r_wave;

    always_ff @(posedge i_clk) begin
        if (i_req.gamma_en) begin
            r_gamma <= GAMMA_ROM[i_req.gamma_addr];
        end
        if (i_req.wave_en) begin
            r_wave <= WAVE_ROM[i_req.wave_addr];
        end
    end

    assign o_rsp.gamma = r_gamma;
    assign o_rsp.wave  = r_wave;

endmodule

`default_nettype wire

// ----- rtl/sgld_engine.sv -----
// Item sequencer and datapath: window test, breathing rate limit, constant
// division, wave scaling and gamma to PWM. Uses sgld_pkg; drives the state memory and ROMs through its ports.
`default_nettype none

module sgld_engine (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sgld_pkg::t_cfg     i_cfg,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire sgld_pkg::t_item    i_item,
    output sgld_pkg::t_st_req       o_st_req,
    input  wire logic [31:0]        i_st_data,
    output sgld_pkg::t_rom_req      o_rom_req,
    input  wire sgld_pkg::t_rom_rsp i_rom_rsp,
    input  wire logic               i_out_free,
    output logic                    o_res_load,
    output sgld_pkg::t_result       o_res
);

    localparam int unsigned DW = sgld_pkg::DIV_W;

    sgld_pkg::t_state r_state;
    sgld_pkg::t_state n_state;
    logic             r_window;

    sgld_pkg::t_item  r_item;
    sgld_pkg::t_phase r_phase;
    logic [31:0]      r_num;
    logic [31:0]      r_q0;
    logic [31:0]      r_q;
    logic [DW-1:0]    r_rem;
    logic [10:0]      r_b;
    logic             r_upd;
    logic [9:0]       r_pwm;

    logic        in_window;
    logic        flag_now;
    logic [6:0]  target;
    logic        upd_now;
    logic [10:0] b_sched;
    logic [31:0] tick_diff;

    logic [DW-1:0] div_p;
    logic [31:0]   div_recip;
    logic [63:0]   prod_m;
    logic [47:0]   prod_c;
    logic [47:0]   rem0;
    logic          corr;

    logic [6:0]  span;
    logic [27:0] wprod;
    logic [11:0] mag;
    logic [11:0] lo16;
    logic [11:0] b_wide;
    logic [10:0] b_breath;

    logic [16:0] inv_g;
    logic [33:0] pwm_prod;

    // Schedule and rate-limit decisions, valid in S_LOAD with the state read.
    always_comb begin
        if (i_cfg.on_min == i_cfg.off_min) begin
            in_window = 1'b0;
        end else if (i_cfg.on_min < i_cfg.off_min) begin
            in_window = (r_item.minute_of_day >= i_cfg.on_min) &&
                        (r_item.minute_of_day < i_cfg.off_min);
        end else begin
            in_window = (r_item.minute_of_day >= i_cfg.on_min) ||
                        (r_item.minute_of_day < i_cfg.off_min);
        end
        flag_now  = i_cfg.sched_en && in_window;
        target    = (!i_cfg.sched_en || flag_now) ? i_cfg.user_pct : 7'd0;
        b_sched   = (target > 7'(sgld_pkg::PCT_MAX)) ?
                    11'(sgld_pkg::PCT_MAX * 16) : {target, 4'b0000};
        tick_diff = r_item.time_ms - i_st_data;
        if (r_item.command == sgld_pkg::CMD_SCHEDULE) begin
            upd_now = r_item.force_req || (target != i_st_data[6:0]);
        end else begin
            upd_now = tick_diff >= 32'(sgld_pkg::BREATH_INTERVAL_MS);
        end
    end

    // Division by a constant: reciprocal multiply, then one correction step.
    always_comb begin
        if (r_phase == sgld_pkg::PH_GAMMA) begin
            div_p     = DW'(sgld_pkg::FULL_SIXTEENTHS);
            div_recip = sgld_pkg::RECIP_FULL;
        end else begin
            div_p     = DW'(sgld_pkg::BREATH_PERIOD_MS);
            div_recip = sgld_pkg::RECIP_PERIOD;
        end
        prod_m = 64'(r_num) * 64'(div_recip);
        prod_c = 48'(r_q0) * 48'(div_p);
        rem0   = 48'(r_num) - prod_c;
        corr   = rem0 >= 48'(div_p);
    end

    // Breathing brightness from the wave sample.
    always_comb begin
        if (i_cfg.breath_max >= i_cfg.breath_min) begin
            span = i_cfg.breath_max - i_cfg.breath_min;
        end else begin
            span = i_cfg.breath_min - i_cfg.breath_max;
        end
        wprod = (28'(i_rom_rsp.wave) * 28'(span)) << 4;
        mag   = 12'((wprod + 28'(sgld_pkg::Q16_HALF)) >> 16);
        lo16  = {1'b0, i_cfg.breath_min, 4'b0000};
        if (i_cfg.breath_max >= i_cfg.breath_min) begin
            b_wide = lo16 + mag;
        end else begin
            b_wide = (lo16 > mag) ? lo16 - mag : 12'd0;
        end
        b_breath = (b_wide > 12'(sgld_pkg::FULL_SIXTEENTHS)) ?
                   11'(sgld_pkg::FULL_SIXTEENTHS) : b_wide[10:0];
    end

    always_comb begin
        inv_g    = 17'(sgld_pkg::Q16_ONE) - i_rom_rsp.gamma;
        pwm_prod = 34'(inv_g) * 34'(sgld_pkg::PWM_MAX) + 34'(sgld_pkg::Q16_HALF);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sgld_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = sgld_pkg::S_LOAD;
                end
            end
            sgld_pkg::S_LOAD: begin
                if (!upd_now) begin
                    n_state = sgld_pkg::S_EMIT;
                end else if (r_item.command == sgld_pkg::CMD_SCHEDULE) begin
                    n_state = sgld_pkg::S_BIDX;
                end else begin
                    n_state = sgld_pkg::S_DIVM;
                end
            end
            sgld_pkg::S_BIDX: n_state = sgld_pkg::S_DIVM;
            sgld_pkg::S_DIVM: n_state = sgld_pkg::S_DIVC;
            sgld_pkg::S_DIVC: begin
                case (r_phase)
                    sgld_pkg::PH_MOD: n_state = sgld_pkg::S_MODX;
                    sgld_pkg::PH_IDX: n_state = sgld_pkg::S_WRD;
                    default:          n_state = sgld_pkg::S_GRD;
                endcase
            end
            sgld_pkg::S_MODX: n_state = sgld_pkg::S_DIVM;
            sgld_pkg::S_WRD:  n_state = sgld_pkg::S_WAVE;
            sgld_pkg::S_WAVE: n_state = sgld_pkg::S_BIDX;
            sgld_pkg::S_GRD:  n_state = sgld_pkg::S_PWM;
            sgld_pkg::S_PWM:  n_state = sgld_pkg::S_EMIT;
            sgld_pkg::S_EMIT: begin
                if (i_out_free) begin
                    n_state = sgld_pkg::S_IDLE;
                end
            end
            default: n_state = sgld_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == sgld_pkg::S_IDLE);

        o_st_req.rd_en   = i_in_valid && (r_state == sgld_pkg::S_IDLE);
        o_st_req.rd_addr = (i_item.command == sgld_pkg::CMD_SCHEDULE) ?
                           sgld_pkg::ST_APPLIED : sgld_pkg::ST_BREATH;
        o_st_req.wr_en   = (r_state == sgld_pkg::S_LOAD) && upd_now;
        if (r_item.command == sgld_pkg::CMD_SCHEDULE) begin
            o_st_req.wr_addr = sgld_pkg::ST_APPLIED;
            o_st_req.wr_data = 32'(target);
        end else begin
            o_st_req.wr_addr = sgld_pkg::ST_BREATH;
            o_st_req.wr_data = r_item.time_ms;
        end

        o_rom_req.gamma_en   = (r_state == sgld_pkg::S_GRD);
        o_rom_req.gamma_addr = r_q[sgld_pkg::GIDX_W-1:0];
        o_rom_req.wave_en    = (r_state == sgld_pkg::S_WRD);
        o_rom_req.wave_addr  = r_q[sgld_pkg::WIDX_W-1:0];

        o_res_load = (r_state == sgld_pkg::S_EMIT) && i_out_free;
        o_res.drive_updated         = r_upd;
        o_res.pwm_level             = r_upd ? r_pwm : 10'd0;
        o_res.status_led            = r_upd && (r_b > 11'(sgld_pkg::STATUS_THRESHOLD));
        o_res.window_active         = r_window;
        o_res.brightness_sixteenths = r_upd ? r_b : 11'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sgld_pkg::S_IDLE;
            r_window <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == sgld_pkg::S_LOAD) &&
                (r_item.command == sgld_pkg::CMD_SCHEDULE)) begin
                r_window <= flag_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            sgld_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    r_item <= i_item;
                end
            end
            sgld_pkg::S_LOAD: begin
                r_upd   <= upd_now;
                r_b     <= b_sched;
                r_num   <= r_item.time_ms;
                r_phase <= sgld_pkg::PH_MOD;
            end
            sgld_pkg::S_BIDX: begin
                r_num   <= 32'(r_b) * 32'(sgld_pkg::TABLE_DEPTH) + 32'(sgld_pkg::HALF_STEP);
                r_phase <= sgld_pkg::PH_GAMMA;
            end
            sgld_pkg::S_DIVM: begin
                r_q0 <= prod_m[63:32];
            end
            sgld_pkg::S_DIVC: begin
                r_q   <= r_q0 + 32'(corr);
                r_rem <= corr ? DW'(rem0 - 48'(div_p)) : DW'(rem0);
            end
            sgld_pkg::S_MODX: begin
                r_num   <= 32'(r_rem) * 32'(sgld_pkg::TABLE_DEPTH);
                r_phase <= sgld_pkg::PH_IDX;
            end
            sgld_pkg::S_WAVE: begin
                r_b <= b_breath;
            end
            sgld_pkg::S_PWM: begin
                r_pwm <= pwm_prod[25:16];
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/scheduled_gamma_led_dimmer.sv -----
// Scheduled gamma-corrected LED dimmer: one item in, one result out per item.
// An item is handled start to finish before the next is taken. The sequencer
// runs the reciprocal-multiply divider (a multiply step, then a correction
// step; three divisions for a breathing tick that passes the rate limit, one
// for a schedule item that rewrites the drive, none for an item that leaves
// the drive alone) and the registered state memory and ROM reads one after
// another. Results wait in an output register, so the next item is accepted
// while one is still pending. No clearing pass follows reset. Configuration
// goes through the APB port, one register every 4 bytes, and reads back what
// was written.
// Depends on sgld_pkg, sgld_state_mem, sgld_rom and sgld_engine.
`default_nettype none

module scheduled_gamma_led_dimmer (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sgld_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic                        i_command,
    input  wire logic [10:0]                 i_minute_of_day,
    input  wire logic                        i_force_req,
    input  wire logic [31:0]                 i_time_ms,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic                             o_drive_updated,
    output logic [9:0]                       o_pwm_level,
    output logic                             o_status_led,
    output logic                             o_window_active,
    output logic [10:0]                      o_brightness_sixteenths
);

    sgld_pkg::t_cfg     r_cfg;
    sgld_pkg::t_reg_idx reg_idx;
    logic               cfg_wr;

    sgld_pkg::t_item    item;
    sgld_pkg::t_st_req  st_req;
    logic [31:0]        st_data;
    sgld_pkg::t_rom_req rom_req;
    sgld_pkg::t_rom_rsp rom_rsp;
    logic               out_free;
    logic               res_load;
    sgld_pkg::t_result  res;

    logic               r_out_valid;
    sgld_pkg::t_result  r_out;

    assign pready  = 1'b1;
    assign reg_idx = paddr[sgld_pkg::APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= sgld_pkg::CFG_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                sgld_pkg::REG_SCHED_EN:   r_cfg.sched_en   <= pwdata[0];
                sgld_pkg::REG_ON_MIN:     r_cfg.on_min     <= pwdata[10:0];
                sgld_pkg::REG_OFF_MIN:    r_cfg.off_min    <= pwdata[10:0];
                sgld_pkg::REG_USER_PCT:   r_cfg.user_pct   <= pwdata[6:0];
                sgld_pkg::REG_BREATH_MIN: r_cfg.breath_min <= pwdata[6:0];
                sgld_pkg::REG_BREATH_MAX: r_cfg.breath_max <= pwdata[6:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            sgld_pkg::REG_SCHED_EN:   prdata = 32'(r_cfg.sched_en);
            sgld_pkg::REG_ON_MIN:     prdata = 32'(r_cfg.on_min);
            sgld_pkg::REG_OFF_MIN:    prdata = 32'(r_cfg.off_min);
            sgld_pkg::REG_USER_PCT:   prdata = 32'(r_cfg.user_pct);
            sgld_pkg::REG_BREATH_MIN: prdata = 32'(r_cfg.breath_min);
            sgld_pkg::REG_BREATH_MAX: prdata = 32'(r_cfg.breath_max);
            default:                  prdata = '0;
        endcase
    end

    assign item.command       = i_command;
    assign item.minute_of_day = i_minute_of_day;
    assign item.force_req     = i_force_req;
    assign item.time_ms       = i_time_ms;

    sgld_state_mem u_state_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (st_req),
        .o_rd_data (st_data)
    );

    sgld_rom u_rom (
        .i_clk (i_clk),
        .i_req (rom_req),
        .o_rsp (rom_rsp)
    );

    sgld_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_item     (item),
        .o_st_req   (st_req),
        .i_st_data  (st_data),
        .o_rom_req  (rom_req),
        .i_rom_rsp  (rom_rsp),
        .i_out_free (out_free),
        .o_res_load (res_load),
        .o_res      (res)
    );

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_drive_updated         = r_out.drive_updated;
    assign o_pwm_level             = r_out.pwm_level;
    assign o_status_led            = r_out.status_led;
    assign o_window_active         = r_out.window_active;
    assign o_brightness_sixteenths = r_out.brightness_sixteenths;

endmodule

`default_nettype wire

// ----- rtl/sgld_checker.sv -----
// Port-level checker for the LED dimmer and its bind to the top level.
// Depends on sgld_pkg and scheduled_gamma_led_dimmer_macros.svh.
`default_nettype none
`include "scheduled_gamma_led_dimmer_macros.svh"

module sgld_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_drive_updated,
    input wire logic [9:0]  o_pwm_level,
    input wire logic        o_status_led,
    input wire logic [10:0] o_brightness_sixteenths
);

    `SGLD_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_pwm_level) && $stable(o_brightness_sixteenths) && $stable(o_drive_updated), "result changed while stalled")

    `SGLD_ASSERT_NOW(a_quiet_result, o_out_valid && !o_drive_updated, (o_pwm_level == 10'd0) && !o_status_led && (o_brightness_sixteenths == 11'd0), "drive fields set without an update")

    `SGLD_ASSERT_NOW(a_status_led, o_out_valid && o_drive_updated, o_status_led == (o_brightness_sixteenths > 11'(sgld_pkg::STATUS_THRESHOLD)), "status LED disagrees with brightness")

    `SGLD_ASSERT_NOW(a_bright_max, o_out_valid, o_brightness_sixteenths <= 11'(sgld_pkg::FULL_SIXTEENTHS), "brightness above full scale")

    `SGLD_ASSERT_NEXT(a_one_item, i_in_valid && o_in_ready, !o_in_ready, "second item taken while busy")

endmodule

bind scheduled_gamma_led_dimmer sgld_checker u_sgld_checker (
    .i_clk                   (i_clk),
    .i_rst_n                 (i_rst_n),
    .i_in_valid              (i_in_valid),
    .o_in_ready              (o_in_ready),
    .o_out_valid             (o_out_valid),
    .i_out_ready             (i_out_ready),
    .o_drive_updated         (o_drive_updated),
    .o_pwm_level             (o_pwm_level),
    .o_status_led            (o_status_led),
    .o_brightness_sixteenths (o_brightness_sixteenths)
);

`default_nettype wire

// ----- tb/scheduled_gamma_led_dimmer_tb.sv -----
// Self-checking testbench for the scheduled gamma LED dimmer: directed and random items,
// APB setups between phases, and a bit-exact predictor of the gamma and breathing drive.
// Depends on sgld_pkg and the scheduled_gamma_led_dimmer RTL only.
module scheduled_gamma_led_dimmer_tb;

    localparam int unsigned QUIET_LIMIT = 5000;
    localparam int unsigned RANDOM_ITEMS = 160;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [sgld_pkg::APB_AW-1:0]   paddr = '0;
    logic [31:0]                   pwdata = '0;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    sgld_pkg::t_item               cur_cmd = '0;
    sgld_pkg::t_result             got_out;

    sgld_pkg::t_item               pending_cmds[$];
    sgld_pkg::t_result             predicted_drive[$];
    int unsigned                   mismatch_count = 0;
    int unsigned                   quiet_cycles = 0;

    sgld_pkg::t_cfg                cfg = sgld_pkg::CFG_RESET;
    logic [6:0]                    applied_pct = '0;
    logic [31:0]                   last_tick_ms = '0;
    logic                          window_on = 1'b0;

    int unsigned                   taken_count = 0;
    int unsigned                   sent_count = 0;
    bit                            drain_req = 1'b0;
    bit                            drain_served = 1'b0;
    bit                            drain_hold = 1'b0;
    bit                            gaps_on = 1'b0;
    bit                            stalls_on = 1'b0;
    int unsigned                   burst_left = 1;
    int unsigned                   gap_left = 0;
    logic [15:0]                   stall_pat = '1;
    logic [4:0]                    stall_tick = '0;
    logic [31:0]                   ms_clock = '0;

    scheduled_gamma_led_dimmer dut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .psel                    (psel),
        .penable                 (penable),
        .pwrite                  (pwrite),
        .paddr                   (paddr),
        .pwdata                  (pwdata),
        .prdata                  (prdata),
        .pready                  (pready),
        .i_in_valid              (i_in_valid),
        .o_in_ready              (o_in_ready),
        .i_command               (cur_cmd.command),
        .i_minute_of_day         (cur_cmd.minute_of_day),
        .i_force_req             (cur_cmd.force_req),
        .i_time_ms               (cur_cmd.time_ms),
        .o_out_valid             (o_out_valid),
        .i_out_ready             (i_out_ready),
        .o_drive_updated         (got_out.drive_updated),
        .o_pwm_level             (got_out.pwm_level),
        .o_status_led            (got_out.status_led),
        .o_window_active         (got_out.window_active),
        .o_brightness_sixteenths (got_out.brightness_sixteenths)
    );

    always #2 i_clk = ~i_clk;

    function automatic sgld_pkg::t_result gamma_drive(input longint unsigned level);
        sgld_pkg::t_result r;
        longint unsigned   b;
        longint unsigned   idx;
        longint unsigned   v;
        longint unsigned   lim;
        longint unsigned   lo;
        longint unsigned   hi;
        longint unsigned   mid;
        longint unsigned   g;
        longint unsigned   pwm;
        b = (level > sgld_pkg::FULL_SIXTEENTHS) ? sgld_pkg::FULL_SIXTEENTHS : level;
        idx = (b * sgld_pkg::TABLE_DEPTH + sgld_pkg::FULL_SIXTEENTHS / 2) /
              sgld_pkg::FULL_SIXTEENTHS;
        g = 0;
        if (idx != 0) begin
            v = (idx * 65536 + sgld_pkg::TABLE_DEPTH / 2) / sgld_pkg::TABLE_DEPTH;
            lim = v << 44;
            lo = 0;
            hi = 4096;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                if (mid * mid * mid * mid * mid <= lim) begin
                    lo = mid;
                end else begin
                    hi = mid - 1;
                end
            end
            g = (v * v * lo + (64'd1 << 27)) >> 28;
        end
        pwm = ((65536 - g) * sgld_pkg::PWM_MAX + 32768) >> 16;
        r = '0;
        r.drive_updated = 1'b1;
        r.pwm_level = pwm[9:0];
        r.status_led = (b > sgld_pkg::STATUS_THRESHOLD);
        r.brightness_sixteenths = b[10:0];
        return r;
    endfunction

    task automatic predict_dimmer(input sgld_pkg::t_item it, output sgld_pkg::t_result r);
        logic            in_window;
        logic [6:0]      target;
        logic [31:0]     elapsed;
        longint unsigned j;
        longint unsigned k;
        longint unsigned t;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned s;
        longint unsigned w;
        longint unsigned b;
        longint unsigned mag;
        r = '0;
        elapsed = it.time_ms - last_tick_ms;
        if (it.command == sgld_pkg::CMD_SCHEDULE) begin
            if (cfg.on_min == cfg.off_min) begin
                in_window = 1'b0;
            end else if (cfg.on_min < cfg.off_min) begin
                in_window = (it.minute_of_day >= cfg.on_min) &&
                            (it.minute_of_day < cfg.off_min);
            end else begin
                in_window = (it.minute_of_day >= cfg.on_min) ||
                            (it.minute_of_day < cfg.off_min);
            end
            window_on = cfg.sched_en && in_window;
            target = (!cfg.sched_en || window_on) ? cfg.user_pct : 7'd0;
            if (it.force_req || target != applied_pct) begin
                applied_pct = target;
                r = gamma_drive(((target > sgld_pkg::PCT_MAX) ? sgld_pkg::PCT_MAX : target) * 16);
            end
        end else if (elapsed >= sgld_pkg::BREATH_INTERVAL_MS) begin
            last_tick_ms = it.time_ms;
            j = it.time_ms % sgld_pkg::BREATH_PERIOD_MS;
            j = j * sgld_pkg::TABLE_DEPTH / sgld_pkg::BREATH_PERIOD_MS;
            k = (sgld_pkg::TABLE_DEPTH - j < j) ? sgld_pkg::TABLE_DEPTH - j : j;
            t = k * sgld_pkg::PI_Q30 / sgld_pkg::TABLE_DEPTH;
            x2 = (t * t) >> 30;
            term = t;
            s = t;
            for (int n = 1; n <= 6; n++) begin
                term = ((term * x2) >> 30) / longint'(2 * n * (2 * n + 1));
                if (n % 2 == 1) begin
                    s = (s > term) ? s - term : 0;
                end else begin
                    s = s + term;
                end
            end
            w = (s * s + (64'd1 << 43)) >> 44;
            if (w > sgld_pkg::Q16_ONE) begin
                w = sgld_pkg::Q16_ONE;
            end
            b = cfg.breath_min * 16;
            if (cfg.breath_max >= cfg.breath_min) begin
                mag = (w * (cfg.breath_max - cfg.breath_min) * 16 + sgld_pkg::Q16_HALF) >> 16;
                b = b + mag;
            end else begin
                mag = (w * (cfg.breath_min - cfg.breath_max) * 16 + sgld_pkg::Q16_HALF) >> 16;
                b = (b > mag) ? b - mag : 0;
            end
            r = gamma_drive(b);
        end
        r.window_active = window_on;
    endtask

    task automatic note_mismatch(input string what, input longint got, input longint want);
        $display("result error at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic write_reg(input sgld_pkg::t_reg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            sgld_pkg::REG_SCHED_EN:   cfg.sched_en = val[0];
            sgld_pkg::REG_ON_MIN:     cfg.on_min = val[10:0];
            sgld_pkg::REG_OFF_MIN:    cfg.off_min = val[10:0];
            sgld_pkg::REG_USER_PCT:   cfg.user_pct = val[6:0];
            sgld_pkg::REG_BREATH_MIN: cfg.breath_min = val[6:0];
            sgld_pkg::REG_BREATH_MAX: cfg.breath_max = val[6:0];
            default: ;
        endcase
    endtask

    task automatic apply_setup(input logic en, input int unsigned on_m, input int unsigned off_m,
                               input int unsigned user, input int unsigned bmin,
                               input int unsigned bmax);
        write_reg(sgld_pkg::REG_SCHED_EN, 32'(en));
        write_reg(sgld_pkg::REG_ON_MIN, on_m);
        write_reg(sgld_pkg::REG_OFF_MIN, off_m);
        write_reg(sgld_pkg::REG_USER_PCT, user);
        write_reg(sgld_pkg::REG_BREATH_MIN, bmin);
        write_reg(sgld_pkg::REG_BREATH_MAX, bmax);
    endtask

    task automatic queue_cmd(input logic cmd, input int unsigned minute, input logic frc,
                             input logic [31:0] ms);
        sgld_pkg::t_item it;
        it.command = cmd;
        it.minute_of_day = minute[10:0];
        it.force_req = frc;
        it.time_ms = ms;
        pending_cmds.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || i_in_valid || predicted_drive.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
    endtask

    function automatic int unsigned pick_minute();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 1439);
    endfunction

    function automatic int unsigned pick_pct();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 100);
    endfunction

    function automatic sgld_pkg::t_item random_cmd();
        sgld_pkg::t_item it;
        it.time_ms = $urandom;
        it.minute_of_day = 11'($urandom_range(0, 2047));
        it.force_req = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < 45) begin
            it.command = sgld_pkg::CMD_SCHEDULE;
            it.minute_of_day = 11'(pick_minute());
        end else begin
            it.command = sgld_pkg::CMD_BREATH;
            case ($urandom_range(0, 19))
                0:       ms_clock = $urandom;
                1:       ms_clock = 32'hFFFF_FFFF - $urandom_range(0, 20);
                default: ms_clock = ms_clock + $urandom_range(0, 12);
            endcase
            it.time_ms = ms_clock;
        end
        return it;
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && (taken_count != sent_count)) begin
        end else begin
            if (drain_hold) begin
                i_in_valid <= 1'b0;
                if (predicted_drive.size() == 0) begin
                    drain_hold <= 1'b0;
                end
            end else if (pending_cmds.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (gap_left != 0) begin
                i_in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if ((drain_req && !drain_served) || $urandom_range(0, 63) == 0) begin
                drain_served <= drain_req;
                drain_hold <= 1'b1;
                i_in_valid <= 1'b0;
            end else begin
                cur_cmd <= pending_cmds.pop_front();
                sent_count <= sent_count + 1;
                i_in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= gaps_on ? $urandom_range(1, 6) : 0;
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            stall_tick <= stall_tick + 1'b1;
            stall_pat <= (stall_tick == 0) ? 16'($urandom) : {stall_pat[0], stall_pat[15:1]};
            i_out_ready <= stalls_on ? stall_pat[0] : 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_block
        sgld_pkg::t_result want;
        sgld_pkg::t_result next_drive;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (predicted_drive.size() == 0) begin
                    note_mismatch("unexpected result, pwm_level", got_out.pwm_level, 0);
                end else begin
                    want = predicted_drive.pop_front();
                    if (got_out.drive_updated !== want.drive_updated)
                        note_mismatch("drive_updated", got_out.drive_updated, want.drive_updated);
                    if (got_out.pwm_level !== want.pwm_level)
                        note_mismatch("pwm_level", got_out.pwm_level, want.pwm_level);
                    if (got_out.status_led !== want.status_led)
                        note_mismatch("status_led", got_out.status_led, want.status_led);
                    if (got_out.window_active !== want.window_active)
                        note_mismatch("window_active", got_out.window_active, want.window_active);
                    if (got_out.brightness_sixteenths !== want.brightness_sixteenths)
                        note_mismatch("brightness_sixteenths", got_out.brightness_sixteenths,
                                      want.brightness_sixteenths);
                end
            end
            if (i_in_valid && o_in_ready) begin
                predict_dimmer(cur_cmd, next_drive);
                predicted_drive.push_back(next_drive);
                taken_count <= taken_count + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        int unsigned on_m;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int p = 0; p < 10; p++) begin
            if (p > 0) begin
                wait_drained();
                case (p)
                    1: apply_setup(1'b1, 1320, 360, 127, 100, 0);
                    2: apply_setup(1'b1, 0, 1439, 100, 0, 100);
                    3: apply_setup(1'b1, 700, 700, 0, 127, 127);
                    4: apply_setup(1'b0, 2047, 0, 50, 0, 0);
                    default: begin
                        on_m = pick_minute();
                        apply_setup($urandom_range(0, 3) != 0, on_m,
                                    ($urandom_range(0, 7) == 0) ? on_m : pick_minute(),
                                    pick_pct(), pick_pct(), pick_pct());
                    end
                endcase
                @(posedge i_clk);
            end
            gaps_on = (p % 3 != 0);
            stalls_on = (p % 4 != 1);
            if (p == 5) begin
                drain_req = 1'b1;
            end
            if (p == 0) begin
                queue_cmd(sgld_pkg::CMD_SCHEDULE, 0, 1'b0, 32'h0);
                queue_cmd(sgld_pkg::CMD_SCHEDULE, 1439, 1'b0, 32'hFFFF_FFFF);
                queue_cmd(sgld_pkg::CMD_SCHEDULE, 2047, 1'b1, 32'h0);
                queue_cmd(sgld_pkg::CMD_BREATH, 0, 1'b0, 32'd0);
                queue_cmd(sgld_pkg::CMD_BREATH, 2047, 1'b1, 32'd4);
                queue_cmd(sgld_pkg::CMD_BREATH, 0, 1'b0, 32'd5);
                queue_cmd(sgld_pkg::CMD_BREATH, 0, 1'b0, 32'd3000);
                queue_cmd(sgld_pkg::CMD_BREATH, 0, 1'b0, 32'd3001);
                queue_cmd(sgld_pkg::CMD_BREATH, 0, 1'b0, 32'd1500);
                queue_cmd(sgld_pkg::CMD_BREATH, 0, 1'b0, 32'd4500);
                queue_cmd(sgld_pkg::CMD_BREATH, 0, 1'b0, 32'd5999);
                queue_cmd(sgld_pkg::CMD_BREATH, 0, 1'b0, 32'd6000);
                queue_cmd(sgld_pkg::CMD_BREATH, 0, 1'b0, 32'hFFFF_FFFE);
                queue_cmd(sgld_pkg::CMD_BREATH, 0, 1'b0, 32'd3);
                queue_cmd(sgld_pkg::CMD_BREATH, 0, 1'b0, 32'hFFFF_FFFF);
                queue_cmd(sgld_pkg::CMD_SCHEDULE, 720, 1'b1, 32'hFFFF_FFFF);
            end else begin
                if (p == 1) begin
                    queue_cmd(sgld_pkg::CMD_SCHEDULE, 1320, 1'b0, 32'h0);
                    queue_cmd(sgld_pkg::CMD_SCHEDULE, 1319, 1'b0, 32'h0);
                    queue_cmd(sgld_pkg::CMD_SCHEDULE, 359, 1'b0, 32'h0);
                    queue_cmd(sgld_pkg::CMD_SCHEDULE, 360, 1'b0, 32'h0);
                    queue_cmd(sgld_pkg::CMD_SCHEDULE, 2047, 1'b1, 32'h0);
                    queue_cmd(sgld_pkg::CMD_BREATH, 0, 1'b0, 32'd3000);
                end
                repeat (RANDOM_ITEMS) pending_cmds.push_back(random_cmd());
            end
        end
        wait_drained();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- scheduled_gamma_led_dimmer.f -----
+incdir+rtl
rtl/sgld_pkg.sv
rtl/sgld_state_mem.sv
rtl/sgld_rom.sv
rtl/sgld_engine.sv
rtl/scheduled_gamma_led_dimmer.sv
rtl/sgld_checker.sv
tb/scheduled_gamma_led_dimmer_tb.sv
